// File: src/iars_pkg.sv
// ----------------------------------------------------------------------------
// iars_pkg
// Shared types and codes for the intake arm and roller sequencer.
// ----------------------------------------------------------------------------
package iars_pkg;

    typedef logic [3:0] mech_code_t;

    localparam mech_code_t ST_HOME      = 4'd0;
    localparam mech_code_t ST_INTAKE    = 4'd1;
    localparam mech_code_t ST_OUTTAKE   = 4'd2;
    localparam mech_code_t ST_DEPLOYED  = 4'd3;
    localparam mech_code_t ST_TOSS      = 4'd4;
    localparam mech_code_t ST_DEPLOYING = 4'd5;
    localparam mech_code_t ST_STOWING   = 4'd6;
    localparam mech_code_t ST_TOSSING   = 4'd7;
    localparam mech_code_t ST_AUTOTOSS  = 4'd8;
    localparam mech_code_t ST_JUICER    = 4'd9;

    // item kinds carried on tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_GOAL = 1'b1;

    // register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_INTAKE_DUTY  = 3'd0;
    localparam cfg_index_t REG_OUTTAKE_DUTY = 3'd1;
    localparam cfg_index_t REG_DEPLOYED_POS = 3'd2;
    localparam cfg_index_t REG_STOWED_POS   = 3'd3;
    localparam cfg_index_t REG_TOSS_POS     = 3'd4;
    localparam cfg_index_t REG_PREJUICE_POS = 3'd5;
    localparam cfg_index_t REG_SQUEEZE_POS  = 3'd6;
    localparam cfg_index_t REG_TOLERANCE    = 3'd7;

    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic signed [15:0] intake_duty;
        logic signed [15:0] outtake_duty;
        logic signed [31:0] deployed_pos;
        logic signed [31:0] stowed_pos;
        logic signed [31:0] toss_pos;
        logic signed [31:0] prejuice_pos;
        logic signed [31:0] squeeze_pos;
        logic        [30:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic               command;
        mech_code_t         goal_state;
        logic signed [31:0] arm_position;
    } item_t;

    typedef struct packed {
        logic               squeeze_phase;
        mech_code_t         mech_state;
        logic               arm_slot;
        logic signed [31:0] arm_setpoint;
        logic               arm_coast;
        logic               arm_update;
        logic signed [15:0] roller_duty;
        logic               roller_update;
    } result_t;

endpackage

// File: src/iars_cfg.sv
// ----------------------------------------------------------------------------
// iars_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module iars_cfg
    import iars_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_INTAKE_DUTY:  cfg_next.intake_duty  = cfg_data[15:0];
                REG_OUTTAKE_DUTY: cfg_next.outtake_duty = cfg_data[15:0];
                REG_DEPLOYED_POS: cfg_next.deployed_pos = cfg_data;
                REG_STOWED_POS:   cfg_next.stowed_pos   = cfg_data;
                REG_TOSS_POS:     cfg_next.toss_pos     = cfg_data;
                REG_PREJUICE_POS: cfg_next.prejuice_pos = cfg_data;
                REG_SQUEEZE_POS:  cfg_next.squeeze_pos  = cfg_data;
                REG_TOLERANCE:    cfg_next.tolerance    = cfg_data[30:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/iars_core.sv
// ----------------------------------------------------------------------------
// iars_core
// Mechanism state registers and the one-pass step logic for goal and tick items.
// ----------------------------------------------------------------------------
module iars_core
    import iars_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    mech_code_t         cur_reg, cur_next;
    mech_code_t         goal_reg, goal_next;
    mech_code_t         ent_state_reg, ent_state_next;
    logic               ent_valid_reg, ent_valid_next;
    logic               home_coast_reg, home_coast_next;
    logic               jphase_reg, jphase_next;
    logic               ent_phase_reg, ent_phase_next;
    logic               phase_valid_reg, phase_valid_next;
    logic signed [31:0] last_pos_reg, last_pos_next;

    logic signed [31:0] target;
    logic signed [32:0] diff;
    logic        [32:0] abs_diff;
    logic               arrived;
    logic               need_entry;

    // one arrival test per tick; the target follows the state
    always_comb begin
        case (cur_reg)
            ST_DEPLOYING: target = cfg.deployed_pos;
            ST_TOSSING:   target = cfg.toss_pos;
            ST_JUICER:    target = cfg.prejuice_pos;
            default:      target = cfg.stowed_pos;
        endcase
    end

    assign diff       = {target[31], target} - {last_pos_reg[31], last_pos_reg};
    assign abs_diff   = diff[32] ? 33'(-diff) : 33'(diff);
    assign arrived    = abs_diff < {2'b00, cfg.tolerance};
    assign need_entry = !ent_valid_reg || (ent_state_reg != cur_reg);

    always_comb begin
        cur_next         = cur_reg;
        goal_next        = goal_reg;
        ent_state_next   = ent_state_reg;
        ent_valid_next   = ent_valid_reg;
        home_coast_next  = home_coast_reg;
        jphase_next      = jphase_reg;
        ent_phase_next   = ent_phase_reg;
        phase_valid_next = phase_valid_reg;
        last_pos_next    = last_pos_reg;

        res = '0;

        if (item.command == CMD_GOAL) begin
            goal_next = item.goal_state;
            if (cur_reg != item.goal_state) begin
                ent_valid_next = 1'b0;
                case (item.goal_state)
                    ST_HOME: cur_next = ST_STOWING;
                    ST_INTAKE, ST_OUTTAKE: begin
                        if (cur_reg == ST_INTAKE || cur_reg == ST_OUTTAKE ||
                            cur_reg == ST_DEPLOYED) begin
                            cur_next = item.goal_state;
                        end else begin
                            cur_next = ST_DEPLOYING;
                        end
                    end
                    ST_DEPLOYED:  cur_next = ST_DEPLOYING;
                    ST_TOSS:      cur_next = ST_TOSSING;
                    ST_AUTOTOSS:  cur_next = ST_AUTOTOSS;
                    ST_JUICER: begin
                        cur_next         = ST_JUICER;
                        jphase_next      = 1'b0;
                        phase_valid_next = 1'b0;
                    end
                    default: cur_next = cur_reg;
                endcase
            end
        end else begin
            last_pos_next = item.arm_position;
            case (cur_reg)
                ST_HOME: begin
                    if (need_entry) begin
                        res.arm_update    = 1'b1;
                        res.arm_setpoint  = cfg.stowed_pos;
                        res.arm_slot      = 1'b1;
                        res.roller_update = 1'b1;
                        ent_state_next    = cur_reg;
                        ent_valid_next    = 1'b1;
                        home_coast_next   = 1'b0;
                    end else if (!home_coast_reg && arrived) begin
                        res.arm_update  = 1'b1;
                        res.arm_coast   = 1'b1;
                        home_coast_next = 1'b1;
                    end
                end
                ST_INTAKE, ST_OUTTAKE, ST_DEPLOYED: begin
                    if (need_entry) begin
                        res.arm_update    = 1'b1;
                        res.arm_coast     = 1'b1;
                        res.roller_update = 1'b1;
                        if (cur_reg == ST_INTAKE) begin
                            res.roller_duty = cfg.intake_duty;
                        end else if (cur_reg == ST_OUTTAKE) begin
                            res.roller_duty = cfg.outtake_duty;
                        end
                        ent_state_next = cur_reg;
                        ent_valid_next = 1'b1;
                    end
                end
                ST_TOSS, ST_TOSSING: begin
                    if (need_entry) begin
                        res.arm_update    = 1'b1;
                        res.arm_setpoint  = cfg.toss_pos;
                        res.arm_slot      = 1'b1;
                        res.roller_update = 1'b1;
                        res.roller_duty   = cfg.intake_duty;
                        ent_state_next    = cur_reg;
                        ent_valid_next    = 1'b1;
                    end
                    if (cur_reg == ST_TOSSING && arrived) begin
                        ent_valid_next = 1'b0;
                        cur_next       = ST_TOSS;
                    end
                end
                ST_DEPLOYING: begin
                    if (need_entry) begin
                        res.arm_update    = 1'b1;
                        res.arm_setpoint  = cfg.deployed_pos;
                        res.roller_update = 1'b1;
                        ent_state_next    = cur_reg;
                        ent_valid_next    = 1'b1;
                    end
                    if (arrived) begin
                        ent_valid_next = 1'b0;
                        if (goal_reg == ST_INTAKE || goal_reg == ST_OUTTAKE) begin
                            cur_next = goal_reg;
                        end else begin
                            cur_next = ST_DEPLOYED;
                        end
                    end
                end
                ST_STOWING: begin
                    if (need_entry) begin
                        res.arm_update    = 1'b1;
                        res.arm_setpoint  = cfg.stowed_pos;
                        res.arm_slot      = 1'b1;
                        res.roller_update = 1'b1;
                        ent_state_next    = cur_reg;
                        ent_valid_next    = 1'b1;
                    end
                    if (arrived) begin
                        ent_valid_next = 1'b0;
                        cur_next       = ST_HOME;
                    end
                end
                ST_JUICER: begin
                    if (need_entry) begin
                        res.roller_update = 1'b1;
                        res.roller_duty   = cfg.intake_duty;
                        ent_state_next    = cur_reg;
                        ent_valid_next    = 1'b1;
                    end
                    // state entry also re-arms the phase entry
                    if ((need_entry || !phase_valid_reg) ||
                        (ent_phase_reg != jphase_reg)) begin
                        res.arm_update   = 1'b1;
                        res.arm_setpoint = jphase_reg ? cfg.squeeze_pos : cfg.prejuice_pos;
                        res.arm_slot     = jphase_reg;
                        ent_phase_next   = jphase_reg;
                        phase_valid_next = 1'b1;
                    end
                    if (!jphase_reg && arrived) begin
                        jphase_next = 1'b1;
                    end
                end
                default: cur_next = cur_reg;  // auto toss idles
            endcase
        end

        res.mech_state    = cur_next;
        res.squeeze_phase = jphase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg         <= ST_HOME;
            goal_reg        <= ST_HOME;
            ent_state_reg   <= ST_HOME;
            ent_valid_reg   <= 1'b0;
            home_coast_reg  <= 1'b0;
            jphase_reg      <= 1'b0;
            ent_phase_reg   <= 1'b0;
            phase_valid_reg <= 1'b0;
            last_pos_reg    <= '0;
        end else if (step_en) begin
            cur_reg         <= cur_next;
            goal_reg        <= goal_next;
            ent_state_reg   <= ent_state_next;
            ent_valid_reg   <= ent_valid_next;
            home_coast_reg  <= home_coast_next;
            jphase_reg      <= jphase_next;
            ent_phase_reg   <= ent_phase_next;
            phase_valid_reg <= phase_valid_next;
            last_pos_reg    <= last_pos_next;
        end
    end

endmodule

// File: src/intake_arm_roller_sequencer.sv
// ----------------------------------------------------------------------------
// intake_arm_roller_sequencer
// Intake arm and roller sequencer: goal and tick items in, one command item out.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then its result in the
// result register, where a stalled output holds it until it is taken.
// Throughput: 1 item per cycle; only a stalled result register holds intake.
// Reset: synchronous, active low; state returns to home, config and valid flags to zero.
// ----------------------------------------------------------------------------
module intake_arm_roller_sequencer
    import iars_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // goal_state[3:0], arm_position[35:4], zero pad
    input  logic                  s_tuser,   // command

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // roller_update[0], roller_duty[16:1], arm_update[17], arm_coast[18],
    // arm_setpoint[50:19], arm_slot[51], mech_state[55:52], squeeze_phase[56], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    iars_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.goal_state   <= s_tdata[3:0];
            in_item_reg.arm_position <= s_tdata[35:4];
        end
    end

    iars_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res_reg};

endmodule
